FILE: rtl/drc_pkg.sv
package drc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEAD_W = 5;

  localparam logic [23:0] ENV_MAX = 24'hFFFFFF;
  localparam logic [23:0] ENV_UNITY = 24'h010000;
  localparam logic signed [15:0] DB_FLOOR = -16'sd25600;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_NOISE_FLOOR = 3'd2;
  localparam logic [2:0] REG_SLOPE = 3'd3;
  localparam logic [2:0] REG_ATTACK = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;
  localparam logic [2:0] REG_MAKEUP = 3'd6;
  localparam logic [2:0] REG_CHANNELS = 3'd7;

  typedef enum logic [1:0] {
    MODE_COMP  = 2'd0,
    MODE_LIMIT = 2'd1,
    MODE_CONST = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] threshold;
    logic signed [15:0] noise_floor;
    logic [15:0]        slope;
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic [15:0]        makeup;
    logic               two;
  } cfg_t;

endpackage

FILE: rtl/drc_cfg.sv
module drc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output drc_pkg::cfg_t      cfg
);

  drc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= drc_pkg::MODE_COMP;
      cfg_r.threshold <= 16'sd0;
      cfg_r.noise_floor <= -16'sd15360;
      cfg_r.slope <= 16'd32768;
      cfg_r.attack_coef <= 16'd64000;
      cfg_r.release_coef <= 16'd65400;
      cfg_r.makeup <= 16'd4096;
      cfg_r.two <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        drc_pkg::REG_MODE:        cfg_r.mode <= drc_pkg::mode_t'(cfg_data[1:0]);
        drc_pkg::REG_THRESHOLD:   cfg_r.threshold <= $signed(cfg_data);
        drc_pkg::REG_NOISE_FLOOR: cfg_r.noise_floor <= $signed(cfg_data);
        drc_pkg::REG_SLOPE:       cfg_r.slope <= cfg_data;
        drc_pkg::REG_ATTACK:      cfg_r.attack_coef <= cfg_data;
        drc_pkg::REG_RELEASE:     cfg_r.release_coef <= cfg_data;
        drc_pkg::REG_MAKEUP:      cfg_r.makeup <= cfg_data;
        drc_pkg::REG_CHANNELS:    cfg_r.two <= cfg_data[1];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/dynamic_range_compressor.sv
// Channel   Handshake           Payload
// in        in_valid/in_stall   in_sample_zero, in_sample_one
// out       out_valid/out_stall out_zero, out_one, out_gain_envelope
// cfg       cfg_we              cfg_index, cfg_data
// Each item runs through the states to ST_DONE before the next is accepted; compressor
// mode above threshold adds the ST_G_CMP step. A silent frame skips the log2 steps,
// and a saturated or vanishing gain target skips the exp series steps. All products go
// through one shared 32x32 multiplier, one after another.
// Reset (rst_n low, synchronous) sets unity envelope and register defaults.
// in_stall stays high while an item is in work or its result waits for the
// output register; a waiting result is held there while the next item enters.
module dynamic_range_compressor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [drc_pkg::SAMPLE_BITS-1:0] in_sample_zero,
  input  logic signed [drc_pkg::SAMPLE_BITS-1:0] in_sample_one,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [drc_pkg::SAMPLE_BITS-1:0] out_zero,
  output logic signed [drc_pkg::SAMPLE_BITS-1:0] out_one,
  output logic [23:0]                           out_gain_envelope,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int SB = drc_pkg::SAMPLE_BITS;
  localparam int LEAD_W_T = drc_pkg::LEAD_W;
  localparam logic [16:0] T_BASE = 17'((SB - 1) * 4096);
  localparam logic [SB-1:0] LIM_POS = SB'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [SB-1:0] LIM_NEG = SB'(64'd1 << (SB - 1));

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOG_INIT, ST_SQ_MUL, ST_SQ_NORM, ST_T_MUL, ST_T_DONE, ST_GAIN,
    ST_G_CMP, ST_EXP_MUL, ST_EXP_SPLIT, ST_Y_MUL, ST_Y_DONE, ST_S_MUL, ST_S_DIV,
    ST_S_RMUL, ST_S_REC, ST_G_LIN, ST_ENV_SEL, ST_ENV_M1, ST_ENV_M2, ST_ENV_SUM,
    ST_TOT_M, ST_TOT_D, ST_O0_M, ST_O1_M, ST_O1_D, ST_DONE
  } state_t;

  drc_pkg::cfg_t cfg;

  drc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  state_t             state_r;
  logic [SB-1:0]      mag0_r, mag1_r, peak_r;
  logic               neg0_r, neg1_r;
  logic [LEAD_W_T-1:0] lead_r;
  logic [30:0]        x_r;
  logic [11:0]        frac_r;
  logic [3:0]         cnt_r;
  logic signed [15:0] lv_r;
  logic signed [17:0] g_r;
  logic signed [7:0]  n_r;
  logic [23:0]        f_r;
  logic [29:0]        y_r;
  logic [30:0]        term_r, pq_r;
  logic [31:0]        sum_r;
  logic [3:0]         idx_r;
  logic [23:0]        target_r, env_r;
  logic [15:0]        coeff_r;
  logic [40:0]        acc_r;
  logic [27:0]        total_r;
  logic [SB-1:0]      o0_r, o1_r;
  logic               out_valid_r;
  logic [SB-1:0]      out_zero_r, out_one_r;
  logic [23:0]        out_env_r;
  logic [63:0]        prod_r, prod_nxt;

  logic [31:0]        mul_a, mul_b;
  logic [SB-1:0]      in_mag0, in_mag1, in_peak;
  logic [LEAD_W_T-1:0] lead;
  logic [SB+31:0]     norm_wide;
  logic [31:0]        sq;
  logic [16:0]        t_val;
  logic [32:0]        q_lv;
  logic signed [17:0] over, thr18, lv18;
  logic [32:0]        q_cmp;
  logic [16:0]        g_mag;
  logic signed [31:0] e_val;
  logic [30:0]        p_div;
  logic [5:0]         sh;
  logic [31:0]        r_lin;
  logic [41:0]        env_sum;
  logic [25:0]        env_new;
  logic [31:0]        recip;

  function automatic logic [SB-1:0] sat_scale(input logic [63:0] p, input logic neg);
    logic [63:0] m;
    m = (p + 64'd32768) >> 16;
    if (neg) begin
      if (m > {{(64-SB){1'b0}}, LIM_NEG}) m = {{(64-SB){1'b0}}, LIM_NEG};
      return SB'(64'd0 - m);
    end
    if (m > {{(64-SB){1'b0}}, LIM_POS}) m = {{(64-SB){1'b0}}, LIM_POS};
    return m[SB-1:0];
  endfunction

  assign in_mag0 = in_sample_zero[SB-1] ? SB'(~in_sample_zero + 1'b1) : in_sample_zero;
  assign in_mag1 = in_sample_one[SB-1] ? SB'(~in_sample_one + 1'b1) : in_sample_one;
  assign in_peak = (cfg.two && in_mag1 > in_mag0) ? in_mag1 : in_mag0;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SB; i++) begin
      if (peak_r[i]) lead = LEAD_W_T'(i);
    end
  end

  always_comb begin
    norm_wide = ({peak_r, 32'd0} >> lead) >> 2;
    sq = prod_r[61:30];
    t_val = (T_BASE > {lead_r, frac_r}) ? T_BASE - {lead_r, frac_r} : 17'd0;
    q_lv = ({1'b0, prod_r[31:0]} + 33'd32768) >> 16;
    lv18 = {{2{lv_r[15]}}, lv_r};
    thr18 = {{2{cfg.threshold[15]}}, cfg.threshold};
    over = lv18 - thr18;
    q_cmp = (prod_r[32:0] + 33'd32768) >> 16;
    g_mag = g_r[17] ? 17'(-g_r) : 17'(g_r);
    e_val = g_r[17] ? -$signed({1'b0, prod_r[30:0]}) : $signed({1'b0, prod_r[30:0]});
    p_div = prod_r[60:30];
    sh = 6'(8'sd14 - n_r);
    r_lin = sum_r >> sh;
    env_sum = {1'b0, acc_r} + {1'b0, prod_r[40:0]} + 42'd32768;
    env_new = env_sum[41:16];
  end

  always_comb begin
    case (idx_r)
      4'd3:    recip = 32'd2863311531;
      4'd5:    recip = 32'd1717986919;
      4'd6:    recip = 32'd1431655766;
      4'd7:    recip = 32'd1227133514;
      default: recip = 32'd0;
    endcase
  end

  // Shared multiplier: operands picked by state, product registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ_MUL: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
      ST_T_MUL: begin
        mul_a = {15'd0, t_val};
        mul_b = 32'd24660;
      end
      ST_GAIN: begin
        mul_a = 32'(over);
        mul_b = {16'd0, cfg.slope};
      end
      ST_EXP_MUL: begin
        mul_a = {15'd0, g_mag};
        mul_b = 32'd10885;
      end
      ST_Y_MUL: begin
        mul_a = {8'd0, f_r};
        mul_b = 32'd744261118;
      end
      ST_S_MUL: begin
        mul_a = {1'b0, term_r};
        mul_b = {2'd0, y_r};
      end
      ST_S_RMUL: begin
        mul_a = {1'b0, pq_r};
        mul_b = recip;
      end
      ST_ENV_M1: begin
        mul_a = {16'd0, coeff_r};
        mul_b = {8'd0, env_r};
      end
      ST_ENV_M2: begin
        mul_a = {15'd0, 17'd65536 - {1'b0, coeff_r}};
        mul_b = {8'd0, target_r};
      end
      ST_TOT_M: begin
        mul_a = {8'd0, env_r};
        mul_b = {16'd0, cfg.makeup};
      end
      ST_O0_M: begin
        mul_a = 32'(mag0_r);
        mul_b = {4'd0, total_r};
      end
      ST_O1_M: begin
        mul_a = 32'(mag1_r);
        mul_b = {4'd0, total_r};
      end
      default: ;
    endcase
    prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      env_r <= drc_pkg::ENV_UNITY;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mag0_r <= in_mag0;
            mag1_r <= in_mag1;
            neg0_r <= in_sample_zero[SB-1];
            neg1_r <= in_sample_one[SB-1];
            peak_r <= in_peak;
            state_r <= ST_LOG_INIT;
          end
        end
        ST_LOG_INIT: begin
          if (peak_r == '0) begin
            lv_r <= drc_pkg::DB_FLOOR;
            state_r <= ST_GAIN;
          end else begin
            lead_r <= lead;
            x_r <= norm_wide[30:0];
            frac_r <= '0;
            cnt_r <= 4'd11;
            state_r <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: state_r <= ST_SQ_NORM;
        ST_SQ_NORM: begin
          // square, and renormalize when the mantissa reaches two
          if (sq[31]) begin
            frac_r[cnt_r] <= 1'b1;
            x_r <= sq[31:1];
          end else begin
            x_r <= sq[30:0];
          end
          cnt_r <= cnt_r - 4'd1;
          state_r <= (cnt_r == 4'd0) ? ST_T_MUL : ST_SQ_MUL;
        end
        ST_T_MUL: state_r <= ST_T_DONE;
        ST_T_DONE: begin
          lv_r <= (q_lv > 33'd25600) ? drc_pkg::DB_FLOOR : -$signed(q_lv[15:0]);
          state_r <= ST_GAIN;
        end
        ST_GAIN: begin
          if (cfg.mode == drc_pkg::MODE_COMP && over > 18'sd0) begin
            state_r <= ST_G_CMP;
          end else begin
            state_r <= ST_EXP_MUL;
          end
          case (cfg.mode)
            drc_pkg::MODE_LIMIT: g_r <= (over > 18'sd0) ? -over : 18'sd0;
            drc_pkg::MODE_CONST: g_r <= (lv_r > cfg.noise_floor) ? thr18 - lv18 : 18'sd0;
            default:             g_r <= '0;
          endcase
        end
        ST_G_CMP: begin
          g_r <= -$signed({1'b0, q_cmp[16:0]});
          state_r <= ST_EXP_MUL;
        end
        ST_EXP_MUL: state_r <= ST_EXP_SPLIT;
        ST_EXP_SPLIT: begin
          n_r <= e_val[31:24];
          f_r <= e_val[23:0];
          if ($signed(e_val[31:24]) >= 8'sd8) begin
            target_r <= drc_pkg::ENV_MAX;
            state_r <= ST_ENV_SEL;
          end else if ($signed(e_val[31:24]) <= -8'sd26) begin
            target_r <= '0;
            state_r <= ST_ENV_SEL;
          end else begin
            state_r <= ST_Y_MUL;
          end
        end
        ST_Y_MUL: state_r <= ST_Y_DONE;
        ST_Y_DONE: begin
          y_r <= prod_r[53:24];
          term_r <= 31'h40000000;
          sum_r <= 32'h40000000;
          idx_r <= 4'd1;
          state_r <= ST_S_MUL;
        end
        ST_S_MUL: state_r <= ST_S_DIV;
        ST_S_DIV: begin
          // powers of two divide by shift, others by reciprocal
          case (idx_r)
            4'd1: begin
              term_r <= p_div;
              sum_r <= sum_r + {1'b0, p_div};
            end
            4'd2: begin
              term_r <= p_div >> 1;
              sum_r <= sum_r + {1'b0, p_div >> 1};
            end
            4'd4: begin
              term_r <= p_div >> 2;
              sum_r <= sum_r + {1'b0, p_div >> 2};
            end
            4'd8: begin
              term_r <= p_div >> 3;
              sum_r <= sum_r + {1'b0, p_div >> 3};
            end
            default: pq_r <= p_div;
          endcase
          if (idx_r == 4'd1 || idx_r == 4'd2 || idx_r == 4'd4 || idx_r == 4'd8) begin
            idx_r <= idx_r + 4'd1;
            state_r <= (idx_r == 4'd8) ? ST_G_LIN : ST_S_MUL;
          end else begin
            state_r <= ST_S_RMUL;
          end
        end
        ST_S_RMUL: state_r <= ST_S_REC;
        ST_S_REC: begin
          term_r <= prod_r[63:33];
          sum_r <= sum_r + {1'b0, prod_r[63:33]};
          idx_r <= idx_r + 4'd1;
          state_r <= ST_S_MUL;
        end
        ST_G_LIN: begin
          target_r <= (r_lin[31:24] != 8'd0) ? drc_pkg::ENV_MAX : r_lin[23:0];
          state_r <= ST_ENV_SEL;
        end
        ST_ENV_SEL: begin
          coeff_r <= (target_r < env_r) ? cfg.attack_coef : cfg.release_coef;
          state_r <= ST_ENV_M1;
        end
        ST_ENV_M1: state_r <= ST_ENV_M2;
        ST_ENV_M2: begin
          acc_r <= prod_r[40:0];
          state_r <= ST_ENV_SUM;
        end
        ST_ENV_SUM: begin
          // prod_r holds the second envelope product here
          env_r <= (env_new[25:24] != 2'd0) ? drc_pkg::ENV_MAX : env_new[23:0];
          state_r <= ST_TOT_M;
        end
        ST_TOT_M: state_r <= ST_TOT_D;
        ST_TOT_D: begin
          total_r <= prod_r[39:12];
          state_r <= ST_O0_M;
        end
        ST_O0_M: state_r <= ST_O1_M;
        ST_O1_M: begin
          o0_r <= sat_scale(prod_r, neg0_r);
          state_r <= ST_O1_D;
        end
        ST_O1_D: begin
          o1_r <= sat_scale(prod_r, neg1_r);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_zero_r <= o0_r;
            out_one_r <= cfg.two ? o1_r : '0;
            out_env_r <= env_r;
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_zero = $signed(out_zero_r);
  assign out_one = $signed(out_one_r);
  assign out_gain_envelope = out_env_r;

endmodule
